// ----- hdl/tkb_pkg.sv -----
// Shared types and constants for the top-k blob selector.
// No dependencies; imported by tkb_cell and top_k_blob_selector.
`default_nettype none

package tkb_pkg;

  // Number of cells in the sorted list.
  localparam int LIST_DEPTH = 16;
  // Width of a count that can hold 0..LIST_DEPTH.
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  // Width of an index into the list.
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  localparam int AREA_W  = 25;
  localparam int COORD_W = 16;
  localparam int POS_W   = 17;
  localparam int SHAPE_W = 16;
  localparam int OFS_W   = 12;
  localparam int MAXC_W  = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 80;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_AREA  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_AREA  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y  = 3'd4;

  // Input item kinds carried on s_tuser.
  localparam logic FUNC_BLOB = 1'b0;
  localparam logic FUNC_EOF  = 1'b1;

  // One stored blob.
  typedef struct packed {
    logic [SHAPE_W-1:0] shape;
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   x;
    logic [AREA_W-1:0]  area;
  } blob_t;

  // Source a cell loads from when enabled.
  typedef enum logic [1:0] {
    SEL_NEW  = 2'd0,  // the incoming blob
    SEL_PREV = 2'd1,  // the neighbor one place up (insertion shift)
    SEL_NEXT = 2'd2   // the neighbor one place down (drain shift)
  } cell_sel_t;

  typedef struct packed {
    logic      en;
    cell_sel_t sel;
  } cell_ctrl_t;

  // Comparison of the incoming area against a cell's stored area.
  typedef struct packed {
    logic ge;  // incoming area >= stored area
    logic gt;  // incoming area >  stored area
  } cell_cmp_t;

endpackage

`default_nettype wire

// ----- hdl/tkb_cell.sv -----
// One slot of the sorted blob list: holds a blob, compares it with the
// incoming area and loads from the new blob or a neighbor. Uses tkb_pkg.
`default_nettype none

module tkb_cell
  import tkb_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire blob_t      new_blob,
  input  wire blob_t      prev_blob,
  input  wire blob_t      next_blob,
  output blob_t           blob,
  output cell_cmp_t       cmp
);

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      case (ctrl.sel)
        SEL_NEW:  blob <= new_blob;
        SEL_PREV: blob <= prev_blob;
        SEL_NEXT: blob <= next_blob;
        default:  blob <= blob;
      endcase
    end
  end

  assign cmp.ge = (new_blob.area >= blob.area);
  assign cmp.gt = (new_blob.area > blob.area);

endmodule

`default_nettype wire

// ----- hdl/top_k_blob_selector.sv -----
// Top level of the top-k blob selector: configuration registers, the chain
// of list cells, list control and the output register. Uses tkb_pkg, tkb_cell.
`default_nettype none

//  Channel   Signals                              Contents (lowest bit first)
//  --------  -----------------------------------  ---------------------------------
//  input     s_tvalid s_tready s_tdata s_tuser    tdata: area, cx, cy, shape; tuser: func
//  output    m_tvalid m_tready m_tdata m_tuser    tdata: area, x, y, shape; tuser: empty
//            m_tlast                              tlast: final result of the frame
//  config    cfg_we cfg_index cfg_data            write only, one register per edge
//
// In a blob transfer every cell compares the new area with its own in
// parallel and the list shifts down by one place from the insertion point,
// so blobs may arrive back to back. An end-of-frame transfer drains the list
// through cell 0 at one result per cycle while the output is not stalled;
// no input is taken while the list drains, until every kept blob (or one
// empty result for an empty list) has gone to the output register. Reset is
// synchronous and clears the count and the control state; the list cells
// need no clearing because only cells below the count are ever read.

module top_k_blob_selector
  import tkb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input stream.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // blob_area, centroid_x, centroid_y,
                                                // shape_factor, zero pad
  input  wire logic                  s_tuser,   // func
  // Result stream.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // out_area, out_x, out_y, out_shape,
                                                // zero pad
  output logic                       m_tuser,   // list_empty
  output logic                       m_tlast,
  // Configuration write port.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  // Configuration registers.
  logic [AREA_W-1:0] min_area;
  logic [AREA_W-1:0] max_area;
  logic [MAXC_W-1:0] max_count;
  logic [OFS_W-1:0]  offset_x;
  logic [OFS_W-1:0]  offset_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_area  <= '0;
      max_area  <= '1;
      max_count <= MAXC_W'(16);
      offset_x  <= '0;
      offset_y  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_AREA:  min_area  <= cfg_data[AREA_W-1:0];
        REG_MAX_AREA:  max_area  <= cfg_data[AREA_W-1:0];
        REG_MAX_COUNT: max_count <= cfg_data[MAXC_W-1:0];
        REG_OFFSET_X:  offset_x  <= cfg_data[OFS_W-1:0];
        REG_OFFSET_Y:  offset_y  <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  state_t           state;
  logic [CNT_W-1:0] count;     // number of valid cells
  logic [CNT_W-1:0] remain;    // results still to send while draining
  logic             drain_empty;

  // Unpack the input item and place the centroid in image coordinates.
  logic [AREA_W-1:0]  in_area;
  logic [COORD_W-1:0] in_cx;
  logic [COORD_W-1:0] in_cy;
  logic [SHAPE_W-1:0] in_shape;
  blob_t              new_blob;

  assign in_area  = s_tdata[AREA_W-1:0];
  assign in_cx    = s_tdata[AREA_W +: COORD_W];
  assign in_cy    = s_tdata[AREA_W+COORD_W +: COORD_W];
  assign in_shape = s_tdata[AREA_W+2*COORD_W +: SHAPE_W];

  assign new_blob.area  = in_area;
  assign new_blob.x     = POS_W'(in_cx) + {1'b0, offset_x, 4'b0000};
  assign new_blob.y     = POS_W'(in_cy) + {1'b0, offset_y, 4'b0000};
  assign new_blob.shape = in_shape;

  // Effective cap: a zero count acts as one, anything above the depth as the depth.
  logic [CNT_W-1:0] cap;
  always_comb begin
    if (max_count == '0) begin
      cap = CNT_W'(1);
    end else if (32'(max_count) > LIST_DEPTH) begin
      cap = CNT_W'(LIST_DEPTH);
    end else begin
      cap = CNT_W'(max_count);
    end
  end

  logic             in_xfer;
  logic             blob_xfer;
  logic             eof_xfer;
  logic             in_window;
  logic             full;
  logic [CNT_W-1:0] last_pos;
  logic             beats_last;
  logic             insert;

  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign blob_xfer = in_xfer && (s_tuser == FUNC_BLOB);
  assign eof_xfer  = in_xfer && (s_tuser == FUNC_EOF);
  assign in_window = (in_area >= min_area) && (in_area <= max_area);
  assign full      = (count >= cap);

  // Cell chain.
  blob_t      cell_blob [LIST_DEPTH];
  cell_cmp_t  cell_cmp  [LIST_DEPTH];
  cell_ctrl_t cell_ctrl [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] take;   // cell receives the new blob or a shifted one
  logic [LIST_DEPTH-1:0] gt_vec;
  logic                  shift_out;

  // A full list takes the blob only if it beats the smallest kept entry.
  assign last_pos   = count - CNT_W'(1);
  assign beats_last = gt_vec[last_pos[IDX_W-1:0]];
  assign insert     = blob_xfer && in_window && (!full || beats_last);

  genvar gi;
  generate
    for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
      logic  occupied;
      logic  in_len;
      blob_t prev_b;
      blob_t next_b;

      assign occupied   = (CNT_W'(gi) < count);
      // Cells at or past the resulting length keep their contents.
      assign in_len     = full ? (CNT_W'(gi) < count) : (CNT_W'(gi) <= count);
      assign take[gi]   = !occupied || cell_cmp[gi].ge;
      assign gt_vec[gi] = cell_cmp[gi].gt;

      if (gi == 0) begin : g_head
        assign prev_b = new_blob;
      end else begin : g_body
        assign prev_b = cell_blob[gi-1];
      end
      if (gi == LIST_DEPTH - 1) begin : g_tail
        assign next_b = '0;
      end else begin : g_mid
        assign next_b = cell_blob[gi+1];
      end

      always_comb begin
        if (shift_out) begin
          cell_ctrl[gi].en  = 1'b1;
          cell_ctrl[gi].sel = SEL_NEXT;
        end else begin
          cell_ctrl[gi].en = insert && in_len && take[gi];
          if (gi > 0 && take[(gi > 0) ? gi - 1 : 0]) begin
            cell_ctrl[gi].sel = SEL_PREV;
          end else begin
            cell_ctrl[gi].sel = SEL_NEW;
          end
        end
      end

      tkb_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl[gi]),
        .new_blob  (new_blob),
        .prev_blob (prev_b),
        .next_blob (next_b),
        .blob      (cell_blob[gi]),
        .cmp       (cell_cmp[gi])
      );
    end
  endgenerate

  // Output register and drain sequencing.
  logic  out_free;
  logic  out_load;
  blob_t out_blob;
  logic  out_empty;
  logic  out_last;

  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = (state == ST_DRAIN) && out_free;
  assign shift_out = out_load && !drain_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      remain      <= '0;
      drain_empty <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // A new result replaces the one leaving in the same cycle.
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (insert && !full) begin
            count <= count + CNT_W'(1);
          end
          if (eof_xfer) begin
            remain      <= count;
            drain_empty <= (count == '0);
            count       <= '0;
            state       <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_load) begin
            remain <= remain - CNT_W'(1);
            if (drain_empty || remain == CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result payload; an empty frame sends zeros with the empty flag.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_blob  <= drain_empty ? '0 : cell_blob[0];
      out_empty <= drain_empty;
      out_last  <= drain_empty || (remain == CNT_W'(1));
    end
  end

  assign m_tdata = OUT_DATA_W'(out_blob);
  assign m_tuser = out_empty;
  assign m_tlast = out_last;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the top-k blob selector: drives blob and end-of-frame
// transfers, predicts the emitted ranking in a small tracker class and checks it.
// Depends on tkb_pkg and top_k_blob_selector.

module tb_top;
  import tkb_pkg::*;

  localparam int LIMIT_TIME = 3000000;
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  // One expected result transfer.
  typedef struct {
    blob_t blob;
    logic  is_empty;
    logic  is_final;
  } emit_t;

  // Tracks the sorted list of the current frame and the results owed to the
  // result stream. Register values mirror what has been written to the block.
  class top_k_tracker;
    logic [AREA_W-1:0] min_area = '0;
    logic [AREA_W-1:0] max_area = AREA_MAX;
    logic [MAXC_W-1:0] max_count = MAXC_W'(16);
    logic [OFS_W-1:0]  ofs_x = '0;
    logic [OFS_W-1:0]  ofs_y = '0;
    blob_t             ranked[LIST_DEPTH];
    int unsigned       kept = 0;
    emit_t             expected_emits[$];
    int unsigned       failures = 0;
    int unsigned       checked = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_MIN_AREA:  min_area = value[AREA_W-1:0];
        REG_MAX_AREA:  max_area = value[AREA_W-1:0];
        REG_MAX_COUNT: max_count = value[MAXC_W-1:0];
        REG_OFFSET_X:  ofs_x = value[OFS_W-1:0];
        REG_OFFSET_Y:  ofs_y = value[OFS_W-1:0];
        default: ;
      endcase
    endfunction

    // Place a blob at the first slot whose area is not larger; the list length
    // becomes len and whatever was shifted beyond it is lost.
    function void place(int unsigned len, blob_t b);
      int unsigned pos;
      int i;
      pos = 0;
      while (pos + 1 < len && pos < kept && b.area < ranked[pos].area) pos++;
      for (i = int'(len) - 1; i > int'(pos); i--) ranked[i] = ranked[i-1];
      ranked[pos] = b;
    endfunction

    // Returns 1 when the item does real work (a frame end or a blob inside
    // the area window).
    function bit note_item(logic func, logic [AREA_W-1:0] area, logic [COORD_W-1:0] cx,
                           logic [COORD_W-1:0] cy, logic [SHAPE_W-1:0] sh);
      int unsigned lim;
      int unsigned k;
      blob_t b;
      emit_t e;
      if (func == FUNC_BLOB) begin
        lim = (max_count == 0) ? 1 : ((max_count > LIST_DEPTH) ? LIST_DEPTH : max_count);
        b.area  = area;
        b.x     = {1'b0, cx} + {1'b0, ofs_x, 4'b0000};
        b.y     = {1'b0, cy} + {1'b0, ofs_y, 4'b0000};
        b.shape = sh;
        if (area < min_area || area > max_area) return 1'b0;
        if (kept >= lim) begin
          // A full list (or one longer than a lowered cap) keeps its length.
          if (area > ranked[kept-1].area) place(kept, b);
        end else begin
          place(kept + 1, b);
          kept++;
        end
        return 1'b1;
      end
      if (kept == 0) begin
        e.blob = '0;
        e.is_empty = 1'b1;
        e.is_final = 1'b1;
        expected_emits = {expected_emits, e};
      end else begin
        for (k = 0; k < kept; k++) begin
          e.blob = ranked[k];
          e.is_empty = 1'b0;
          e.is_final = (k + 1 == kept);
          expected_emits = {expected_emits, e};
        end
        kept = 0;
      end
      return 1'b1;
    endfunction

    function void check_emit(blob_t got, logic got_empty, logic got_final);
      emit_t e;
      if (expected_emits.size() == 0) begin
        $error("result transfer with nothing expected: area %0d", got.area);
        failures++;
        return;
      end
      e = expected_emits.pop_front();
      checked++;
      if (got.area !== e.blob.area) begin
        $error("out_area: expected %0d, got %0d", e.blob.area, got.area);
        failures++;
      end
      if (got.x !== e.blob.x) begin
        $error("out_x: expected %0d, got %0d", e.blob.x, got.x);
        failures++;
      end
      if (got.y !== e.blob.y) begin
        $error("out_y: expected %0d, got %0d", e.blob.y, got.y);
        failures++;
      end
      if (got.shape !== e.blob.shape) begin
        $error("out_shape: expected %0d, got %0d", e.blob.shape, got.shape);
        failures++;
      end
      if (got_empty !== e.is_empty) begin
        $error("list_empty: expected %0d, got %0d", e.is_empty, got_empty);
        failures++;
      end
      if (got_final !== e.is_final) begin
        $error("last: expected %0d, got %0d", e.is_final, got_final);
        failures++;
      end
    endfunction

    function int unsigned pending_count();
      return expected_emits.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  top_k_tracker tracker;
  bit           no_idle = 1'b0;     // suppresses sender gaps for a whole frame
  int unsigned  items_counted = 0;  // blobs inside the window plus frame ends
  int unsigned  frames = 0;
  int unsigned  settings = 0;

  top_k_blob_selector u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
    ,
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Every result transfer is sampled at the edge where it completes. The
  // output registers update after this process reads them, so the sample is
  // the value the handshake actually moved.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      tracker.check_emit(m_tdata[AREA_W+2*POS_W+SHAPE_W-1:0], m_tuser, m_tlast);
    end
  end

  // The receiver alternates bursts of readiness with stalls of random length,
  // and every so often stays ready for a long stretch.
  initial begin
    int unsigned run_len;
    int unsigned stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                            : $urandom_range(1, 20);
      m_tready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Offers one item and holds it until the block takes it. When no gap
  // follows, s_tvalid stays high and the next call replaces the data in the
  // same time step.
  task automatic send_item(logic func, logic [AREA_W-1:0] area, logic [COORD_W-1:0] cx,
                           logic [COORD_W-1:0] cy, logic [SHAPE_W-1:0] sh);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {{(IN_DATA_W-AREA_W-3*COORD_W){1'b0}}, sh, cy, cx, area};
    do @(posedge clk); while (!s_tready);
    if (tracker.note_item(func, area, cx, cy, sh)) items_counted++;
    if (func == FUNC_EOF) frames++;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_blob(logic [AREA_W-1:0] area);
    send_item(FUNC_BLOB, area, COORD_W'($urandom_range(0, 65535)),
              COORD_W'($urandom_range(0, 65535)), SHAPE_W'($urandom_range(0, 65535)));
  endtask

  // The contents of a frame-end transfer are ignored, so they carry noise.
  task automatic end_frame();
    send_item(FUNC_EOF, AREA_W'($urandom), COORD_W'($urandom_range(0, 65535)),
              COORD_W'($urandom_range(0, 65535)), SHAPE_W'($urandom_range(0, 65535)));
  endtask

  // The sender stops, waits for every owed result and then lets the clock run
  // on so that the last blob is done inside the block before any register
  // changes.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all five registers, one per edge, then drops the write enable.
  task automatic set_config(logic [AREA_W-1:0] lo, logic [AREA_W-1:0] hi,
                            logic [MAXC_W-1:0] cnt, logic [OFS_W-1:0] ox,
                            logic [OFS_W-1:0] oy);
    logic [CFG_DATA_W-1:0] vals[5];
    logic [CFG_IDX_W-1:0]  idx[5];
    int i;
    vals = '{CFG_DATA_W'(lo), CFG_DATA_W'(hi), CFG_DATA_W'(cnt), CFG_DATA_W'(ox),
             CFG_DATA_W'(oy)};
    idx  = '{REG_MIN_AREA, REG_MAX_AREA, REG_MAX_COUNT, REG_OFFSET_X, REG_OFFSET_Y};
    for (i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      tracker.set_reg(idx[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic random_config();
    logic [AREA_W-1:0] lo;
    logic [AREA_W-1:0] hi;
    logic [MAXC_W-1:0] cnt;
    logic [OFS_W-1:0]  ox;
    logic [OFS_W-1:0]  oy;
    int unsigned r;
    r = $urandom_range(0, 99);
    lo = (r < 40) ? '0 : (r < 70) ? AREA_W'($urandom_range(0, 5000)) : AREA_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 40 || lo > AREA_MAX - 200000) hi = AREA_MAX;
    else hi = lo + AREA_W'($urandom_range(0, 200000));
    // Now and then the window is inverted, so the frame keeps nothing.
    if ($urandom_range(0, 19) == 0 && lo != 0) hi = lo - 1'b1;
    r = $urandom_range(0, 99);
    cnt = (r < 10) ? '0 : (r < 20) ? MAXC_W'($urandom_range(17, 31)) :
          (r < 30) ? MAXC_W'(16) : (r < 40) ? MAXC_W'(1) : MAXC_W'($urandom_range(1, 16));
    r = $urandom_range(0, 99);
    ox = (r < 20) ? '0 : (r < 40) ? '1 : OFS_W'($urandom_range(0, 4095));
    r = $urandom_range(0, 99);
    oy = (r < 20) ? '0 : (r < 40) ? '1 : OFS_W'($urandom_range(0, 4095));
    set_config(lo, hi, cnt, ox, oy);
  endtask

  // Areas: some anywhere in the field, most inside the window, and many
  // bunched near its low edge so that equal areas compete for a place.
  function automatic logic [AREA_W-1:0] pick_area();
    logic [AREA_W-1:0] lo;
    logic [AREA_W-1:0] hi;
    int unsigned r;
    lo = tracker.min_area;
    hi = tracker.max_area;
    r = $urandom_range(0, 99);
    if (lo > hi || r < 12) return AREA_W'($urandom);
    if (r < 50) return lo + AREA_W'($urandom % (32'(hi - lo) + 1));
    return lo + AREA_W'($urandom_range(0, (hi - lo > 24) ? 24 : 32'(hi - lo)));
  endfunction

  // One random frame; sometimes the cap is set anew, no higher than before,
  // partway through, after some of the frame's blobs have been sent.
  task automatic random_frame();
    int unsigned n;
    int unsigned r;
    int unsigned k;
    int unsigned cut;
    r = $urandom_range(0, 99);
    n = (r < 10) ? 0 : (r < 75) ? $urandom_range(1, 6) :
        (r < 92) ? $urandom_range(7, 16) : $urandom_range(17, 24);
    cut = ($urandom_range(0, 9) == 0 && n > 1) ? $urandom_range(1, n - 1) : n;
    no_idle = ($urandom_range(0, 4) == 0);
    for (k = 0; k < n; k++) begin
      if (k == cut) begin
        drain();
        set_config(tracker.min_area, tracker.max_area,
                   MAXC_W'($urandom_range(0, tracker.max_count)),
                   tracker.ofs_x, tracker.ofs_y);
      end
      send_blob(pick_area());
    end
    end_frame();
    no_idle = 1'b0;
  endtask

  initial begin
    tracker   = new();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= FUNC_BLOB;
    cfg_we    <= 1'b0;
    cfg_index <= REG_MIN_AREA;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Widest window, deepest list and the largest offsets.
    set_config('0, AREA_MAX, MAXC_W'(16), '1, '1);
    // A frame end on an empty list gives a single result marked empty.
    end_frame();
    // Field extremes, then two equal areas: the later one must rank first.
    send_item(FUNC_BLOB, AREA_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(FUNC_BLOB, '0, 16'h0000, 16'h0000, 16'h0000);
    send_blob(AREA_W'(100));
    send_blob(AREA_W'(100));
    send_blob(AREA_W'(200));
    end_frame();
    drain();

    // A cap of zero behaves as one: equal areas are refused, a larger one
    // replaces the only entry and a smaller one is refused.
    set_config('0, AREA_MAX, '0, '0, '0);
    send_blob(AREA_W'(50));
    send_blob(AREA_W'(50));
    send_blob(AREA_W'(70));
    send_blob(AREA_W'(10));
    end_frame();
    drain();

    // A cap above the list depth, and an inverted window that keeps nothing.
    set_config(AREA_W'(1000), AREA_W'(999), '1, OFS_W'(1), OFS_W'(2));
    send_blob(AREA_W'(1000));
    send_blob(AREA_W'(999));
    end_frame();
    drain();

    // Window edges are inclusive; then the cap drops below the current list
    // length mid-frame, which leaves the list full at its old length.
    set_config(AREA_W'(10), AREA_W'(500), MAXC_W'(16), '0, '0);
    send_blob(AREA_W'(300));
    send_blob(AREA_W'(5));
    send_blob(AREA_W'(600));
    send_blob(AREA_W'(10));
    send_blob(AREA_W'(500));
    send_blob(AREA_W'(250));
    drain();
    set_config(AREA_W'(10), AREA_W'(500), MAXC_W'(2), '0, '0);
    send_blob(AREA_W'(20));
    send_blob(AREA_W'(8));
    send_blob(AREA_W'(15));
    end_frame();

    // Random frames until enough real work and results have gone through.
    items_counted = 0;
    while (items_counted < 220 || tracker.checked < 60) begin
      if ($urandom_range(0, 9) < 3) begin
        drain();
        random_config();
      end else if ($urandom_range(0, 9) == 0) begin
        drain();
      end
      random_frame();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d frames through %0d register settings; %0d result transfers checked.",
             frames, settings, tracker.checked);
    if (tracker.failures == 0 && tracker.pending_count() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Far beyond the slowest legal run: every item and result hit by the
  // longest gaps on both sides.
  initial begin
    #(LIMIT_TIME);
    $display("tb_top failed");
    $finish;
  end

endmodule
